// ----- hw/rtl/rmq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Fixed-point widths and pipeline depths used by the core and the
// normalization search lanes.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Fraction bits of input and output fields.
    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;
    localparam int N_ENTRY   = 9;
    localparam int N_COMP    = 4;

    // Scaled vector components, their magnitudes and squares.
    localparam int V_W  = DATA_W + 2;
    localparam int A_W  = V_W - 1;
    localparam int SQ_W = 2 * A_W;
    localparam int S_W  = SQ_W + 2;

    // Target of the search (a^2 * 2^(2F+2)) and the running residual.
    localparam int T_W  = SQ_W + 2 * FRAC_BITS + 2;
    localparam int R_W  = T_W + 6;
    localparam int E_W  = S_W + FRAC_BITS + 3;

    // One result bit per search stage.
    localparam int N_ITER = FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;

    // Front stages (vector, squares, sum), search stages, output register.
    localparam int N_FRONT = 3;
    localparam int N_STG   = N_FRONT + N_ITER + 1;

    localparam logic signed [V_W-1:0]    ONE_V   = V_W'(1) <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] ONE_OUT = DATA_W'(1) <<< FRAC_BITS;

endpackage

// ----- hw/rtl/rmq_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normalization search lane
// Finds the largest q with (2q-1)^2 * s <= t, one result bit per stage,
// using only shifts and adds on a running residual.
// ----------------------------------------------------------------------------
module rmq_search (
    input  logic                         clk,
    input  logic                         en,
    input  logic [rmq_pkg::T_W-1:0]      tv,
    input  logic [rmq_pkg::S_W-1:0]      sv,
    output logic [rmq_pkg::Q_W-1:0]      q
);

    localparam int N = rmq_pkg::N_ITER;

    // Stage registers: residual t - e^2*s, e*s with e = 2q-1, partial q, s.
    logic signed [rmq_pkg::R_W-1:0] r_reg [N];
    logic signed [rmq_pkg::E_W-1:0] e_reg [N];
    logic [rmq_pkg::Q_W-1:0]        q_reg [N];
    logic [rmq_pkg::S_W-1:0]        s_reg [N];

    // Values entering each stage; index 0 is the start point q = 0, e = -1.
    logic signed [rmq_pkg::R_W-1:0] r_in [N+1];
    logic signed [rmq_pkg::E_W-1:0] e_in [N+1];
    logic [rmq_pkg::Q_W-1:0]        q_in [N+1];
    logic [rmq_pkg::S_W-1:0]        s_in [N+1];

    assign r_in[0] = $signed(rmq_pkg::R_W'(tv)) - $signed(rmq_pkg::R_W'(sv));
    assign e_in[0] = -$signed(rmq_pkg::E_W'(sv));
    assign q_in[0] = '0;
    assign s_in[0] = sv;

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_stage
            localparam int K = N - 1 - j;

            logic signed [rmq_pkg::R_W-1:0] r_next;
            logic signed [rmq_pkg::E_W-1:0] e_next;
            logic [rmq_pkg::Q_W-1:0]        q_next;
            logic signed [rmq_pkg::R_W-1:0] cand;
            logic signed [rmq_pkg::R_W-1:0] e_ext;
            logic signed [rmq_pkg::R_W-1:0] s_ext;

            // Trial of bit K: (e + 2^(K+1))^2 s = e^2 s + 2^(K+2) e s + 2^(2K+2) s.
            always_comb
            begin
                e_ext  = rmq_pkg::R_W'(e_in[j]);
                s_ext  = $signed(rmq_pkg::R_W'(s_in[j]));
                cand   = r_in[j] - (e_ext <<< (K + 2)) - (s_ext <<< (2 * K + 2));
                r_next = r_in[j];
                e_next = e_in[j];
                q_next = q_in[j];
                if (!cand[rmq_pkg::R_W-1])
                begin
                    r_next = cand;
                    e_next = e_in[j] + ($signed(rmq_pkg::E_W'(s_in[j])) <<< (K + 1));
                    q_next = q_in[j] | (rmq_pkg::Q_W'(1) << K);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j] <= r_next;
                    e_reg[j] <= e_next;
                    q_reg[j] <= q_next;
                    s_reg[j] <= s_in[j];
                end
            end

            assign r_in[j+1] = r_reg[j];
            assign e_in[j+1] = e_reg[j];
            assign q_in[j+1] = q_reg[j];
            assign s_in[j+1] = s_reg[j];
        end
    endgenerate

    assign q = q_in[N];

endmodule

// ----- hw/rtl/rotation_matrix_to_quaternion_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core
// Converts a 3x3 rotation matrix (signed Q2.14) to a unit quaternion
// (signed Q2.14) by Shepperd's method with exact rounded normalization.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one matrix per
//   transaction, nine 16-bit entries r11 .. r33 from the lowest bit up.
//   The master channel (m_tvalid, m_tready, m_tdata) returns one quaternion
//   per matrix: quat_x, quat_y, quat_z, quat_w from the lowest bit up.
//   A matrix passes through three front stages (branch vector, squares,
//   sum of squares), fifteen search stages (one result bit each, four lanes
//   in parallel) and the output register. Throughput is one matrix per
//   cycle while the output is not stalled; every stage is a fully registered
//   step, so a new transaction enters each cycle.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; no result is presented after reset until
//   a matrix has passed through. Items are independent.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // r11, r12, r13, r21, r22, r23, r31, r32, r33
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // quat_x, quat_y, quat_z, quat_w
);

    localparam int DW = rmq_pkg::DATA_W;
    localparam int VW = rmq_pkg::V_W;
    localparam int NC = rmq_pkg::N_COMP;
    localparam int NI = rmq_pkg::N_ITER;

    logic en;
    logic [rmq_pkg::N_STG-1:0] vld_reg;
    logic [rmq_pkg::N_STG-1:0] vld_next;

    // Global advance: the pipeline moves unless a waiting result is stalled.
    assign en       = !(vld_reg[rmq_pkg::N_STG-1] && !m_tready);
    assign s_tready = en;
    assign m_tvalid = vld_reg[rmq_pkg::N_STG-1];
    assign vld_next = {vld_reg[rmq_pkg::N_STG-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: trace test, pivot choice and scaled vector.
    logic signed [VW-1:0] r [rmq_pkg::N_ENTRY];
    logic signed [VW-1:0] tr;
    logic signed [VW-1:0] p;
    logic signed [VW-1:0] v_next [NC];
    logic                 id_next;
    logic signed [VW-1:0] v_reg [NC];
    logic                 id1_reg;

    always_comb
    begin
        for (int i = 0; i < rmq_pkg::N_ENTRY; i++)
        begin
            r[i] = VW'($signed(s_tdata[DW*i +: DW]));
        end
        tr = r[0] + r[4] + r[8];
        if (tr > 0)
        begin
            p = rmq_pkg::ONE_V + tr;
            v_next[0] = r[5] - r[7];
            v_next[1] = r[6] - r[2];
            v_next[2] = r[1] - r[3];
            v_next[3] = p;
        end
        else if (r[0] >= r[4] && r[0] >= r[8])
        begin
            p = rmq_pkg::ONE_V + r[0] - r[4] - r[8];
            v_next[0] = p;
            v_next[1] = r[1] + r[3];
            v_next[2] = r[2] + r[6];
            v_next[3] = r[5] - r[7];
        end
        else if (r[4] > r[8])
        begin
            p = rmq_pkg::ONE_V + r[4] - r[8] - r[0];
            v_next[0] = r[3] + r[1];
            v_next[1] = p;
            v_next[2] = r[7] + r[5];
            v_next[3] = r[6] - r[2];
        end
        else
        begin
            p = rmq_pkg::ONE_V + r[8] - r[0] - r[4];
            v_next[0] = r[6] + r[2];
            v_next[1] = r[7] + r[5];
            v_next[2] = p;
            v_next[3] = r[1] - r[3];
        end
        // A pivot that is not positive only comes from a non-rotation.
        id_next = (p <= 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            id1_reg <= id_next;
        end
    end

    // Stage 2: magnitudes and squares.
    logic [rmq_pkg::A_W-1:0]  a_val [NC];
    logic [rmq_pkg::SQ_W-1:0] sq_reg [NC];
    logic [NC-1:0]            neg2_reg;
    logic                     id2_reg;

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            a_val[i] = v_reg[i][VW-1] ? rmq_pkg::A_W'(-v_reg[i])
                                      : rmq_pkg::A_W'(v_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NC; i++)
            begin
                sq_reg[i]   <= a_val[i] * a_val[i];
                neg2_reg[i] <= v_reg[i][VW-1];
            end
            id2_reg <= id1_reg;
        end
    end

    // Stage 3: sum of squares and per-lane search targets.
    logic [rmq_pkg::S_W-1:0] s_reg;
    logic [rmq_pkg::T_W-1:0] t_reg [NC];
    logic [NC-1:0]           neg3_reg;
    logic                    id3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= rmq_pkg::S_W'(sq_reg[0]) + rmq_pkg::S_W'(sq_reg[1])
                   + rmq_pkg::S_W'(sq_reg[2]) + rmq_pkg::S_W'(sq_reg[3]);
            for (int i = 0; i < NC; i++)
            begin
                t_reg[i] <= {sq_reg[i], (2 * rmq_pkg::FRAC_BITS + 2)'(0)};
            end
            neg3_reg <= neg2_reg;
            id3_reg  <= id2_reg;
        end
    end

    // Search lanes, one per component.
    logic [rmq_pkg::Q_W-1:0] q [NC];

    genvar c;
    generate
        for (c = 0; c < NC; c++)
        begin : g_lane
            rmq_search u_search (
                .clk (clk),
                .en  (en),
                .tv  (t_reg[c]),
                .sv  (s_reg),
                .q   (q[c])
            );
        end
    endgenerate

    // Side flags travel alongside the search stages.
    logic [NC-1:0] neg_dly_reg [NI];
    logic          id_dly_reg [NI];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_dly_reg[0] <= neg3_reg;
            id_dly_reg[0]  <= id3_reg;
            for (int i = 1; i < NI; i++)
            begin
                neg_dly_reg[i] <= neg_dly_reg[i-1];
                id_dly_reg[i]  <= id_dly_reg[i-1];
            end
        end
    end

    // Output register: restore signs, identity for a degenerate pivot.
    logic signed [DW-1:0] quat_next [NC];
    logic signed [DW-1:0] quat_reg [NC];

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            quat_next[i] = neg_dly_reg[NI-1][i] ? -$signed(DW'(q[i])) : $signed(DW'(q[i]));
        end
        if (id_dly_reg[NI-1])
        begin
            quat_next[0] = '0;
            quat_next[1] = '0;
            quat_next[2] = '0;
            quat_next[3] = rmq_pkg::ONE_OUT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_reg <= quat_next;
        end
    end

    assign m_tdata = {quat_reg[3], quat_reg[2], quat_reg[1], quat_reg[0]};

endmodule

// ----- tb/sv/rmq_quat_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: result checker
// Watches both stream channels, computes the expected quaternion for every
// accepted matrix and compares each returned quaternion, field by field,
// with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module rmq_quat_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,   // r11, r12, r13, r21, r22, r23, r31, r32, r33
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,   // quat_x, quat_y, quat_z, quat_w
    output int           fail_count,
    output int           outstanding,
    output int           quats_seen
);

    localparam longint ONE_L = longint'(1) << rmq_pkg::FRAC_BITS;

    logic [63:0] quat_q[$];

    // Rounded v * ONE / sqrt(s), half away from zero, by a search on the
    // squared boundary so that no square root is needed.
    function automatic logic [15:0] unit_lane(longint v, longint unsigned s);
        longint unsigned mag;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned d;
        logic [127:0] target;
        logic [127:0] prod;
        longint unsigned cap;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        lo = 0;
        hi = ONE_L;
        target = 128'(mag * mag) << (2 * rmq_pkg::FRAC_BITS + 2);
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            d = 2 * mid - 1;
            prod = 128'(d * d) * 128'(s);
            if (prod <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        cap = (ONE_L > 32767) ? 32767 : ONE_L;
        if (lo > cap)
            lo = cap;
        return (v < 0) ? 16'(-longint'(lo)) : 16'(lo);
    endfunction

    // Shepperd branch selection, scaled vector, then exact normalization.
    function automatic logic [63:0] quat_of_matrix(logic [143:0] m);
        longint r[9];
        longint t;
        longint p;
        longint v[4];
        longint unsigned s;
        longint unsigned a;
        logic [63:0] q;
        for (int i = 0; i < 9; i++)
            r[i] = longint'($signed(m[16*i +: 16]));
        t = r[0] + r[4] + r[8];
        if (t > 0)
        begin
            p = ONE_L + t;
            v[0] = r[5] - r[7]; v[1] = r[6] - r[2]; v[2] = r[1] - r[3]; v[3] = p;
        end
        else if (r[0] >= r[4] && r[0] >= r[8])
        begin
            p = ONE_L + r[0] - r[4] - r[8];
            v[0] = p; v[1] = r[1] + r[3]; v[2] = r[2] + r[6]; v[3] = r[5] - r[7];
        end
        else if (r[4] > r[8])
        begin
            p = ONE_L + r[4] - r[8] - r[0];
            v[0] = r[3] + r[1]; v[1] = p; v[2] = r[7] + r[5]; v[3] = r[6] - r[2];
        end
        else
        begin
            p = ONE_L + r[8] - r[0] - r[4];
            v[0] = r[6] + r[2]; v[1] = r[7] + r[5]; v[2] = p; v[3] = r[1] - r[3];
        end
        // A pivot that is not positive falls back to the identity rotation.
        if (p <= 0)
        begin
            q = '0;
            q[63:48] = (ONE_L > 32767) ? 16'd32767 : 16'(ONE_L);
            return q;
        end
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            a = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            s += a * a;
        end
        for (int i = 0; i < 4; i++)
            q[16*i +: 16] = unit_lane(v[i], s);
        return q;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    // Queue the prediction on every input transaction and check every output one.
    always @(posedge clk)
    begin
        logic [63:0] want;
        string lane_name[4];
        lane_name = '{"quat_x", "quat_y", "quat_z", "quat_w"};
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                quat_q.push_back(quat_of_matrix(s_tdata));
            if (m_tvalid && m_tready)
            begin
                quats_seen = quats_seen + 1;
                if (quat_q.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = quat_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[16*i +: 16] !== want[16*i +: 16])
                            report_mismatch(lane_name[i], $signed(m_tdata[16*i +: 16]),
                                            $signed(want[16*i +: 16]));
                end
            end
            outstanding = quat_q.size();
        end
        else
        begin
            quat_q.delete();
            fail_count = 0;
            outstanding = 0;
            quats_seen = 0;
        end
    end

endmodule

// ----- tb/sv/rotation_matrix_to_quaternion_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core testbench
// Streams directed and random matrices into the core with random gaps and
// output stalls, including one long output stall and one full drain, and
// leaves checking to the companion checker module.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core_tb;

    localparam int N_RANDOM = 1200;
    localparam logic signed [15:0] P1 = 16'sd16384;
    localparam logic signed [15:0] M1 = -16'sd16384;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;   // r11, r12, r13, r21, r22, r23, r31, r32, r33
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // quat_x, quat_y, quat_z, quat_w

    int fail_count;
    int outstanding;
    int quats_seen;
    int matrices_sent;
    bit long_stall_req;
    bit timed_out;

    rotation_matrix_to_quaternion_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rmq_quat_checker quat_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .quats_seen  (quats_seen)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [143:0] pack_matrix(logic signed [15:0] e[9]);
        logic [143:0] m;
        for (int i = 0; i < 9; i++)
            m[16*i +: 16] = e[i];
        return m;
    endfunction

    // Signed permutation matrix times one, with a little noise per entry.
    function automatic logic [143:0] near_rotation(int noise);
        logic signed [15:0] e[9];
        int perm[3];
        int j;
        int tmp;
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
        end
        for (int i = 0; i < 9; i++)
            e[i] = 16'($urandom_range(0, 2 * noise)) - 16'(noise);
        for (int i = 0; i < 3; i++)
            e[3 * i + perm[i]] += $urandom_range(0, 1) ? P1 : M1;
        return pack_matrix(e);
    endfunction

    function automatic logic [143:0] random_matrix();
        logic signed [15:0] e[9];
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            for (int i = 0; i < 9; i++)
                e[i] = 16'($urandom());
            return pack_matrix(e);
        end
        else if (kind < 8)
            return near_rotation($urandom_range(0, 1) ? 200 : 3000);
        for (int i = 0; i < 9; i++)
            e[i] = 16'($urandom_range(0, 40000)) - 16'sd20000;
        return pack_matrix(e);
    endfunction

    // Offer one matrix, hold it until accepted, then maybe idle.
    task automatic send_matrix(logic [143:0] m);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        matrices_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_entries(logic signed [15:0] e[9]);
        send_matrix(pack_matrix(e));
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        int gap;
        bit stall_done;
        stall_done = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall_req && !stall_done)
            begin
                m_tready <= 1'b0;
                repeat (80) @(posedge clk);
                stall_done = 1'b1;
                m_tready <= 1'b1;
            end
            else
            begin
                gap = gap_len();
                if (gap == 0 || $urandom_range(0, 3) == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    // Safety net against a hung handshake.
    initial
    begin
        #5ms;
        timed_out = 1'b1;
        $display("timeout with %0d quaternions outstanding", outstanding);
        $display("rotation_matrix_to_quaternion_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        matrices_sent = 0;
        long_stall_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: identity, half and quarter turns about each axis, degenerate matrices, field extremes.
        send_entries('{P1, 0, 0, 0, P1, 0, 0, 0, P1});
        send_entries('{P1, 0, 0, 0, M1, 0, 0, 0, M1});
        send_entries('{M1, 0, 0, 0, P1, 0, 0, 0, M1});
        send_entries('{M1, 0, 0, 0, M1, 0, 0, 0, P1});
        send_entries('{M1, 0, 0, 0, M1, 0, 0, 0, M1});
        send_entries('{0, P1, 0, M1, 0, 0, 0, 0, P1});
        send_entries('{0, 0, P1, 0, P1, 0, M1, 0, 0});
        send_entries('{P1, 0, 0, 0, 0, P1, 0, M1, 0});
        send_entries('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_entries('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                       16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_entries('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                       16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_entries('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                       16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        send_entries('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                       16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        // Ties between diagonal entries and a trace of exactly zero.
        send_entries('{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000});
        send_entries('{16'sd8192, 100, -100, 50, 16'sd8192, 7, 9, -3, -16'sd16384});
        send_entries('{-16'sd8192, 0, 0, 0, 16'sd8192, 0, 0, 0, 16'sd8192});
        send_entries('{-16'sd8192, 5, 6, 7, 16'sd4096, 8, 9, 10, 16'sd4096});
        send_entries('{16'sd1, 16'sh7fff, 16'sh8000, 16'sh8000, -16'sd1, 16'sh7fff,
                       16'sh7fff, 16'sh8000, 16'sd0});
        send_entries('{16'sd11585, -16'sd11585, 0, 16'sd11585, 16'sd11585, 0,
                       0, 0, 16'sd16384});

        // Random part, with a long output stall and one full drain on the way.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
                long_stall_req = 1'b1;
            if (n == 700)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            send_matrix(random_matrix());
        end
        s_tvalid <= 1'b0;

        // Drain and let the pipeline settle.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (rmq_pkg::N_STG + 10) @(posedge clk);

        $display("Sent %0d matrices (directed axes, extremes, branch ties, random)",
                 matrices_sent);
        $display("and checked %0d quaternions under random gaps and output stalls.",
                 quats_seen);
        if (fail_count == 0 && !timed_out)
            $display("rotation_matrix_to_quaternion_core_tb: PASS");
        else
            $display("rotation_matrix_to_quaternion_core_tb: FAIL");
        $finish;
    end

endmodule

// ----- rotation_matrix_to_quaternion_core.f -----
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_search.sv
hw/rtl/rotation_matrix_to_quaternion_core.sv
tb/sv/rmq_quat_checker.sv
tb/sv/rotation_matrix_to_quaternion_core_tb.sv
